FILE: rtl/dlft_pkg.sv
package dlft_pkg;

  // Fixed field widths.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned LAMP_W  = 2;
  localparam int unsigned SECS_W  = 9;
  localparam int unsigned RATE_W  = 3;
  localparam int unsigned HP_W    = 10;
  localparam int unsigned MS_W    = 10;
  localparam int unsigned REG_W   = 2;
  localparam int unsigned NUM_CH  = 2;

  // Default limits, handed to the top level as parameter defaults.
  localparam int unsigned MAX_FLASH_SECONDS_DEF = 300;
  localparam int unsigned TICKS_PER_SECOND_DEF  = 1000;

  // Configuration reset values.
  localparam logic [HP_W-1:0] SLOW_HP_RST   = HP_W'(1000);
  localparam logic [HP_W-1:0] MEDIUM_HP_RST = HP_W'(500);
  localparam logic [HP_W-1:0] FAST_HP_RST   = HP_W'(200);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP_ALL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STATUS   = 3'd4;

  // Lamp codes.
  localparam logic [LAMP_W-1:0] LAMP_WHITE = 2'd0;
  localparam logic [LAMP_W-1:0] LAMP_RED   = 2'd1;

  // Rate codes.
  localparam logic [RATE_W-1:0] RATE_STEADY = 3'd0;
  localparam logic [RATE_W-1:0] RATE_LOW    = 3'd1;
  localparam logic [RATE_W-1:0] RATE_HIGH   = 3'd3;

  // Register indexes.
  localparam logic [REG_W-1:0] REG_SLOW_HP   = 2'd0;
  localparam logic [REG_W-1:0] REG_MEDIUM_HP = 2'd1;
  localparam logic [REG_W-1:0] REG_FAST_HP   = 2'd2;

  // Saturation limits of the counters.
  localparam logic [SECS_W-1:0] SECS_MAX  = '1;
  localparam logic [HP_W-1:0]   SINCE_MAX = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [LAMP_W-1:0] lamp_select;
    logic [SECS_W-1:0] flash_seconds;
    logic [RATE_W-1:0] flash_rate;
  } dlft_in_t;

  typedef struct packed {
    logic              white_lamp_on;
    logic              red_lamp_on;
    logic              request_error;
    logic              flashing_now;
    logic [SECS_W-1:0] seconds_left;
  } dlft_out_t;

  typedef struct packed {
    logic [HP_W-1:0] slow;
    logic [HP_W-1:0] mid;
    logic [HP_W-1:0] fast;
  } dlft_hp_t;

  // Per-channel strobes, each valid for exactly one cycle per item.
  typedef struct packed {
    logic tick;
    logic start;
    logic stop;
  } dlft_ctl_t;

  // Per-channel status seen by the top level.
  typedef struct packed {
    logic              active;
    logic              lamp_nxt;
    logic [SECS_W-1:0] left;
  } dlft_stat_t;

endpackage

FILE: rtl/dlft_cfg.sv
module dlft_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dlft_pkg::REG_W-1:0]    cfg_index,
  input  logic [dlft_pkg::HP_W-1:0]     cfg_data,
  output dlft_pkg::dlft_hp_t            hp
);

  dlft_pkg::dlft_hp_t hp_r;
  dlft_pkg::dlft_hp_t hp_nxt;

  assign cfg_ready = 1'b1;
  assign hp        = hp_r;

  // Writes to indexes beyond the register list are taken and dropped.
  always_comb begin
    hp_nxt = hp_r;
    if (cfg_valid) begin
      case (cfg_index)
        dlft_pkg::REG_SLOW_HP:   hp_nxt.slow = cfg_data;
        dlft_pkg::REG_MEDIUM_HP: hp_nxt.mid  = cfg_data;
        dlft_pkg::REG_FAST_HP:   hp_nxt.fast = cfg_data;
        default:                 hp_nxt      = hp_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r.slow <= dlft_pkg::SLOW_HP_RST;
      hp_r.mid  <= dlft_pkg::MEDIUM_HP_RST;
      hp_r.fast <= dlft_pkg::FAST_HP_RST;
    end else begin
      hp_r <= hp_nxt;
    end
  end

endmodule

FILE: rtl/dlft_chan.sv
module dlft_chan #(
  parameter int unsigned TICKS_PER_SECOND = dlft_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dlft_pkg::dlft_ctl_t            ctl,
  input  logic [dlft_pkg::SECS_W-1:0]    flash_seconds,
  input  logic [dlft_pkg::RATE_W-1:0]    flash_rate,
  input  dlft_pkg::dlft_hp_t             hp,
  output dlft_pkg::dlft_stat_t           stat
);

  logic                          active_r,  active_nxt;
  logic [dlft_pkg::RATE_W-1:0]   rate_r,    rate_nxt;
  logic [dlft_pkg::SECS_W-1:0]   dur_r,     dur_nxt;
  logic [dlft_pkg::SECS_W-1:0]   elapsed_r, elapsed_nxt;
  logic [dlft_pkg::MS_W-1:0]     millis_r,  millis_nxt;
  logic [dlft_pkg::HP_W-1:0]     since_r,   since_nxt;
  logic                          first_r,   first_nxt;
  logic                          lamp_r,    lamp_nxt;
  logic [dlft_pkg::HP_W-1:0]     half_period;

  always_comb begin
    case (rate_r)
      dlft_pkg::RATE_LOW:  half_period = hp.slow;
      dlft_pkg::RATE_HIGH: half_period = hp.fast;
      default:             half_period = hp.mid;
    endcase
  end

  always_comb begin
    active_nxt  = active_r;
    rate_nxt    = rate_r;
    dur_nxt     = dur_r;
    elapsed_nxt = elapsed_r;
    millis_nxt  = millis_r;
    since_nxt   = since_r;
    first_nxt   = first_r;
    lamp_nxt    = lamp_r;
    if (ctl.start) begin
      active_nxt  = 1'b1;
      rate_nxt    = flash_rate;
      dur_nxt     = flash_seconds;
      elapsed_nxt = '0;
      millis_nxt  = '0;
      since_nxt   = '0;
      first_nxt   = (flash_rate != dlft_pkg::RATE_STEADY);
      lamp_nxt    = (flash_rate == dlft_pkg::RATE_STEADY);
    end else if (ctl.stop) begin
      active_nxt = 1'b0;
      lamp_nxt   = 1'b0;
    end else if (ctl.tick && active_r) begin
      // Time advances first; a job that times out does not toggle.
      millis_nxt = millis_r + 1'b1;
      if (millis_nxt >= dlft_pkg::MS_W'(TICKS_PER_SECOND)) begin
        millis_nxt = '0;
        if (elapsed_r != dlft_pkg::SECS_MAX) begin
          elapsed_nxt = elapsed_r + 1'b1;
        end
      end
      if (elapsed_nxt >= dur_r) begin
        active_nxt = 1'b0;
        lamp_nxt   = 1'b0;
      end else if (rate_r != dlft_pkg::RATE_STEADY) begin
        if (first_r) begin
          first_nxt = 1'b0;
          lamp_nxt  = ~lamp_r;
          since_nxt = '0;
        end else begin
          if (since_r != dlft_pkg::SINCE_MAX) begin
            since_nxt = since_r + 1'b1;
          end
          if (since_nxt >= half_period) begin
            lamp_nxt  = ~lamp_r;
            since_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      rate_r    <= '0;
      dur_r     <= '0;
      elapsed_r <= '0;
      millis_r  <= '0;
      since_r   <= '0;
      first_r   <= 1'b0;
      lamp_r    <= 1'b0;
    end else begin
      active_r  <= active_nxt;
      rate_r    <= rate_nxt;
      dur_r     <= dur_nxt;
      elapsed_r <= elapsed_nxt;
      millis_r  <= millis_nxt;
      since_r   <= since_nxt;
      first_r   <= first_nxt;
      lamp_r    <= lamp_nxt;
    end
  end

  assign stat.active   = active_r;
  assign stat.lamp_nxt = lamp_nxt;
  assign stat.left     = (active_r && (dur_r > elapsed_r)) ? (dur_r - elapsed_r) : '0;

endmodule

FILE: rtl/dual_lamp_flash_timer.sv
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_stall  | dlft_in_t: command, lamp, seconds, rate
// out_    | output    | out_valid / out_stall| dlft_out_t: lamp levels, error, status
// cfg_    | input     | cfg_valid / cfg_ready| cfg_index (2 bit), cfg_data (10 bit)
//
// Every item passes through the input register and then the result register
// on its way to a result. One item is accepted every cycle unless a stall holds it.
// Reset (rst_n low, synchronous) turns both lamps off, ends all jobs and loads
// the default half periods. A stall on the result side holds the result
// register and, through the input register, stalls the input channel.
module dual_lamp_flash_timer #(
  parameter int unsigned MAX_FLASH_SECONDS = dlft_pkg::MAX_FLASH_SECONDS_DEF,
  parameter int unsigned TICKS_PER_SECOND  = dlft_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dlft_pkg::dlft_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dlft_pkg::dlft_out_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dlft_pkg::REG_W-1:0]    cfg_index,
  input  logic [dlft_pkg::HP_W-1:0]     cfg_data
);

  // Input register: holds the item that is decoded and applied this cycle.
  logic                 s1_valid_r, s1_valid_nxt;
  dlft_pkg::dlft_in_t   s1_r;
  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  dlft_pkg::dlft_out_t  out_r, out_nxt;

  logic                 advance;
  logic                 lamp_bad;
  logic                 secs_bad;
  logic                 req_err;
  logic                 ch_sel;
  dlft_pkg::dlft_hp_t   hp;
  dlft_pkg::dlft_stat_t stat [dlft_pkg::NUM_CH];

  // The item in the input register moves on, and its state changes commit,
  // whenever the result register is empty or is being emptied.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  assign s1_valid_nxt  = in_stall ? 1'b1 : in_valid;
  assign out_valid_nxt = advance ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  // Request checks. Lamp codes above red are unsupported, and a start needs
  // a duration between one second and the configured maximum.
  assign lamp_bad = (s1_r.lamp_select > dlft_pkg::LAMP_RED);
  assign secs_bad = (s1_r.flash_seconds == '0) ||
                    (s1_r.flash_seconds > dlft_pkg::SECS_W'(MAX_FLASH_SECONDS));
  assign ch_sel   = s1_r.lamp_select[0];

  always_comb begin
    case (s1_r.command)
      dlft_pkg::CMD_START:  req_err = lamp_bad || secs_bad;
      dlft_pkg::CMD_STOP:   req_err = lamp_bad;
      dlft_pkg::CMD_STATUS: req_err = lamp_bad;
      default:              req_err = 1'b0;
    endcase
  end

  // Per-channel strobes. Rejected requests and unknown commands touch no state.
  for (genvar ch = 0; ch < dlft_pkg::NUM_CH; ch++) begin : g_ch
    logic                hit;
    dlft_pkg::dlft_ctl_t ctl;
    assign hit = !lamp_bad && (ch_sel == 1'(ch));

    always_comb begin
      ctl = '0;
      if (advance) begin
        case (s1_r.command)
          dlft_pkg::CMD_TICK:     ctl.tick  = 1'b1;
          dlft_pkg::CMD_START:    ctl.start = hit && !secs_bad;
          dlft_pkg::CMD_STOP:     ctl.stop  = hit;
          dlft_pkg::CMD_STOP_ALL: ctl.stop  = 1'b1;
          default:                ctl       = '0;
        endcase
      end
    end

    dlft_chan #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_chan (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .flash_seconds (s1_r.flash_seconds),
      .flash_rate    (s1_r.flash_rate),
      .hp            (hp),
      .stat          (stat[ch])
    );
  end

  dlft_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hp        (hp)
  );

  // Result: lamp levels after the item, plus status fields only for an
  // accepted status query. Status reads state before the item, which a
  // status query never changes.
  always_comb begin
    out_nxt.white_lamp_on = stat[0].lamp_nxt;
    out_nxt.red_lamp_on   = stat[1].lamp_nxt;
    out_nxt.request_error = req_err;
    out_nxt.flashing_now  = 1'b0;
    out_nxt.seconds_left  = '0;
    if ((s1_r.command == dlft_pkg::CMD_STATUS) && !lamp_bad) begin
      out_nxt.flashing_now = ch_sel ? stat[1].active : stat[0].active;
      out_nxt.seconds_left = ch_sel ? stat[1].left   : stat[0].left;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
